// ===== src/smx_pkg.sv =====
// Package for the stack machine execute core.
// Holds transaction types, opcodes, cell control codes and sizing constants.
// No dependencies.
package smx_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WORD_W      = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_DUP    = 4'd1,
    CMD_JUMPIF = 4'd2,
    CMD_MUL    = 4'd3,
    CMD_OVER   = 4'd4,
    CMD_PUSH   = 4'd5,
    CMD_READ   = 4'd6,
    CMD_SWAP   = 4'd7,
    CMD_WRITE  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_ABOVE = 2'd1,
    CELL_FROM_BELOW = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] immediate;
    logic signed [31:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic               jump_taken;
    logic signed [31:0] jump_target;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic [4:0]         stack_depth;
    logic               overflow;
  } out_item_t;

endpackage

// ===== src/smx_cell.sv =====
// One operand stack cell: holds a word, or takes it from the neighbor above
// or below. Depends on smx_pkg.
module smx_cell (
  input  logic             clk,
  input  smx_pkg::cell_op_t op,
  input  smx_pkg::word_t   above_word,
  input  smx_pkg::word_t   below_word,
  output smx_pkg::word_t   word
);
  import smx_pkg::*;

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    case (op)
      CELL_FROM_ABOVE: word_nxt = above_word;
      CELL_FROM_BELOW: word_nxt = below_word;
      default:         word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== src/stack_machine_execute_core.sv =====
// Top level of the stack machine execute core.
// Decodes one instruction per transaction and drives a row of smx_cell
// instances that form the operand stack. Depends on smx_pkg and smx_cell.
//
//   channel  ports                          direction  payload
//   in       in_valid, in_stall, in_data     input      in_item_t
//   out      out_valid, out_stall, out_data  output     out_item_t
//
// One instruction per cycle while in_stall is low; its result is registered
// in the output register on acceptance. The stack top sits in cell 0 and
// the stack shifts through the cell row by one place per instruction. Reset
// clears depth count and output valid; cells are undefined until written.
// in_stall is raised only while a result waits and out_stall is high.
module stack_machine_execute_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  smx_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smx_pkg::out_item_t   out_data
);
  import smx_pkg::*;

  word_t                cell_word [STACK_DEPTH];
  cell_op_t             cell_op   [STACK_DEPTH];
  word_t                load_word;
  logic [DEPTH_W-1:0]   depth_r;
  logic [DEPTH_W-1:0]   depth_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  out_item_t            res;
  logic                 in_fire;
  logic                 has_one;
  logic                 has_two;
  logic                 full;
  logic                 do_push;
  logic                 do_pop;
  logic                 do_alu;
  logic                 do_swap;
  word_t                alu_word;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign has_one = depth_r != '0;
  assign has_two = depth_r > DEPTH_W'(1);
  assign full    = depth_r == DEPTH_W'(STACK_DEPTH);

  always_comb begin
    res         = '0;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    do_alu      = 1'b0;
    do_swap     = 1'b0;
    load_word   = in_data.immediate;
    alu_word    = cell_word[0] + cell_word[1];
    case (in_data.cmd)
      CMD_ADD, CMD_MUL: begin
        if (in_data.cmd == CMD_MUL) begin
          alu_word = cell_word[0] * cell_word[1];
        end
        if (has_two) begin
          do_alu    = 1'b1;
          load_word = alu_word;
        end
      end
      CMD_DUP: begin
        load_word = cell_word[0];
        if (has_one) begin
          res.overflow = full;
          do_push      = ~full;
        end
      end
      CMD_JUMPIF: begin
        if (has_one) begin
          do_pop         = 1'b1;
          res.jump_taken = ~cell_word[0][WORD_W-1];
          if (!cell_word[0][WORD_W-1]) begin
            res.jump_target = in_data.immediate;
          end
        end
      end
      CMD_OVER: begin
        load_word = cell_word[1];
        if (has_two) begin
          res.overflow = full;
          do_push      = ~full;
        end
      end
      CMD_PUSH: begin
        res.overflow = full;
        do_push      = ~full;
      end
      CMD_READ: begin
        load_word    = in_data.read_value;
        res.overflow = full;
        do_push      = ~full;
      end
      CMD_SWAP: begin
        do_swap = has_two;
      end
      CMD_WRITE: begin
        if (has_one) begin
          do_pop          = 1'b1;
          res.write_valid = 1'b1;
          res.write_value = cell_word[0];
        end
      end
      default: begin
      end
    endcase

    depth_nxt = depth_r;
    if (do_push) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end else if (do_pop || do_alu) begin
      depth_nxt = depth_r - DEPTH_W'(1);
    end
    res.stack_depth = 5'(depth_nxt);
  end

  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (in_fire) begin
        if (do_push) begin
          cell_op[i] = CELL_FROM_ABOVE;
        end else if (do_pop) begin
          cell_op[i] = CELL_FROM_BELOW;
        end else if (do_alu) begin
          cell_op[i] = (i == 0) ? CELL_FROM_ABOVE : CELL_FROM_BELOW;
        end else if (do_swap) begin
          if (i == 0) begin
            cell_op[i] = CELL_FROM_BELOW;
          end else if (i == 1) begin
            cell_op[i] = CELL_FROM_ABOVE;
          end
        end
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    word_t above;
    word_t below;
    if (g == 0) begin : g_top
      assign above = load_word;
    end else begin : g_mid_above
      assign above = cell_word[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bottom
      assign below = cell_word[g];
    end else begin : g_mid_below
      assign below = cell_word[g+1];
    end
    smx_cell u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .above_word (above),
      .below_word (below),
      .word       (cell_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
